[design/fmtp_pkg.sv]
package fmtp_pkg;

	localparam int FINGERS   = 8;
	localparam int MODES     = 2;
	localparam int POS_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int DIV_STEPS = 8;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		CMD_REST     = 3'd0,
		CMD_GRIP     = 3'd1,
		CMD_RELEASE  = 3'd2,
		CMD_CLASH    = 3'd3,
		CMD_CHANGE   = 3'd4
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_PRECISION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_M0_CLENCH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_M0_RELEASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_M1_CLENCH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_M1_RELEASE = 3'd6;

	typedef struct packed {
		logic capture;
		logic mul;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic skip_div;
	} dp_stat_t;

endpackage

[design/finger_motor_task_planner.sv]
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | req_type, demand_value, demand_max, current_pos_0..7
// out     | out_valid / out_ready  | drive_enable, drive_direction, speed, active_command,
//         |                        | active_mode
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A command passes through capture, multiply, a division that is skipped when not needed,
// and the output write; the 8-step restoring divider forms the speed one quotient bit a cycle.
// A new command is taken once the previous one has been written to the output register.
// A stalled result holds the last step until the output register frees up.
// Reset loads the register defaults and clears mode and held outputs; no clearing pass.
// Configuration writes are always ready and take effect in the cycle after the transfer.
module finger_motor_task_planner
	import fmtp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           req_type,
	input  logic [7:0]           demand_value,
	input  logic [7:0]           demand_max,
	input  logic [7:0]           current_pos_0,
	input  logic [7:0]           current_pos_1,
	input  logic [7:0]           current_pos_2,
	input  logic [7:0]           current_pos_3,
	input  logic [7:0]           current_pos_4,
	input  logic [7:0]           current_pos_5,
	input  logic [7:0]           current_pos_6,
	input  logic [7:0]           current_pos_7,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           drive_enable,
	output logic [7:0]           drive_direction,
	output logic [7:0]           speed,
	output logic [2:0]           active_command,
	output logic                 active_mode
);

	ctrl_cmd_t        cmd;
	dp_stat_t         stat;
	logic [POS_W-1:0] pos_in [FINGERS];

	assign cfg_ready = 1'b1;

	assign pos_in[0] = current_pos_0;
	assign pos_in[1] = current_pos_1;
	assign pos_in[2] = current_pos_2;
	assign pos_in[3] = current_pos_3;
	assign pos_in[4] = current_pos_4;
	assign pos_in[5] = current_pos_5;
	assign pos_in[6] = current_pos_6;
	assign pos_in[7] = current_pos_7;

	fmtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fmtp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.demand_value    (demand_value),
		.demand_max      (demand_max),
		.pos_in          (pos_in),
		.cmd             (cmd),
		.stat            (stat),
		.drive_enable    (drive_enable),
		.drive_direction (drive_direction),
		.speed           (speed),
		.active_command  (active_command),
		.active_mode     (active_mode)
	);

endmodule

[design/fmtp_ctrl.sv]
module fmtp_ctrl
	import fmtp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.mul      = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = (state_q == S_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q  <= '0;
					state_q <= stat.skip_div ? S_DONE : S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// The held outputs are rewritten only once the previous result is gone.
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[design/fmtp_datapath.sv]
module fmtp_datapath
	import fmtp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [2:0]           req_type,
	input  logic [7:0]           demand_value,
	input  logic [7:0]           demand_max,
	input  logic [POS_W-1:0]     pos_in [FINGERS],
	input  ctrl_cmd_t            cmd,
	output dp_stat_t             stat,
	output logic [7:0]           drive_enable,
	output logic [7:0]           drive_direction,
	output logic [7:0]           speed,
	output logic [2:0]           active_command,
	output logic                 active_mode
);

	logic [7:0]       precision_q;
	logic [7:0]       period_q;
	logic [1:0]       mode_count_q;
	logic [CFG_W-1:0] clench_q  [MODES];
	logic [CFG_W-1:0] release_q [MODES];

	logic [2:0]       kind_q;
	logic [7:0]       demand_q;
	logic [7:0]       dmax_q;
	logic [POS_W-1:0] pos_q [FINGERS];
	logic [7:0]       rem_q;
	logic [7:0]       lo_q;

	logic [7:0]       enable_q;
	logic [7:0]       direction_q;
	logic [7:0]       speed_q;
	logic [2:0]       command_q;
	logic             mode_q;

	logic [15:0]      product;
	logic [8:0]       trial;
	logic             qbit;
	logic             next_mode;
	logic             sel_mode;
	logic [CFG_W-1:0] target;
	logic [7:0]       plan_en;
	logic [7:0]       plan_dir;
	logic [7:0]       plan_speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q  <= 8'd4;
			period_q     <= 8'd255;
			mode_count_q <= 2'd1;
			for (int m = 0; m < MODES; m++) begin
				clench_q[m]  <= '0;
				release_q[m] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRECISION:  precision_q  <= cfg_data[7:0];
				REG_PERIOD:     period_q     <= cfg_data[7:0];
				REG_MODE_COUNT: mode_count_q <= cfg_data[1:0];
				REG_M0_CLENCH:  clench_q[0]  <= cfg_data;
				REG_M0_RELEASE: release_q[0] <= cfg_data;
				REG_M1_CLENCH:  clench_q[MODES-1]  <= cfg_data;
				REG_M1_RELEASE: release_q[MODES-1] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero full scale, or demand at or above it, saturates the quotient at the period.
	assign stat.skip_div = (dmax_q == 8'd0) || (demand_q >= dmax_q);

	assign product = {8'd0, demand_q} * {8'd0, period_q};
	assign trial   = {rem_q, lo_q[7]};
	assign qbit    = (trial >= {1'b0, dmax_q});

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= req_type;
			demand_q <= (req_type == CMD_CHANGE) ? demand_max : demand_value;
			dmax_q   <= demand_max;
			for (int i = 0; i < FINGERS; i++) begin
				pos_q[i] <= pos_in[i];
			end
		end
		if (cmd.mul) begin
			rem_q <= product[15:8];
			lo_q  <= product[7:0];
		end
		// Restoring division; the quotient shifts into the low byte.
		if (cmd.div_step) begin
			rem_q <= qbit ? 8'(trial - {1'b0, dmax_q}) : trial[7:0];
			lo_q  <= {lo_q[6:0], qbit};
		end
	end

	assign next_mode = (mode_count_q >= 2'(MODES)) ? ~mode_q : 1'b0;
	assign sel_mode  = (kind_q == CMD_CHANGE) ? next_mode : mode_q;
	assign target    = (kind_q == CMD_GRIP) ? clench_q[sel_mode] : release_q[sel_mode];

	always_comb begin
		plan_en  = '0;
		plan_dir = '0;
		for (int i = 0; i < FINGERS; i++) begin
			logic [7:0] t;
			logic [7:0] gap;
			t = target[8*i +: 8];
			if (t < pos_q[i]) begin
				gap = pos_q[i] - t;
			end else begin
				gap = t - pos_q[i];
				plan_dir[i] = 1'b1;
			end
			plan_en[i] = (gap >= precision_q);
		end
	end

	assign plan_speed = stat.skip_div ? period_q : lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= '0;
			direction_q <= '0;
			speed_q     <= '0;
			command_q   <= CMD_REST;
			mode_q      <= 1'b0;
		end else if (cmd.finish) begin
			case (kind_q)
				CMD_GRIP, CMD_RELEASE, CMD_CHANGE: begin
					enable_q    <= plan_en;
					direction_q <= plan_dir;
					speed_q     <= plan_speed;
					command_q   <= kind_q;
					mode_q      <= sel_mode;
				end
				CMD_CLASH: begin
					command_q <= CMD_CLASH;
				end
				default: begin
					command_q <= CMD_REST;
				end
			endcase
		end
	end

	assign drive_enable    = enable_q;
	assign drive_direction = direction_q;
	assign speed           = speed_q;
	assign active_command  = command_q;
	assign active_mode     = mode_q;

endmodule

[design/fmtp_checker.sv]
module fmtp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] drive_enable,
	input logic [7:0] drive_direction,
	input logic [7:0] speed,
	input logic [2:0] active_command,
	input logic       active_mode
);

	// A result that waits must hold still until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_enable)
			&& $stable(drive_direction) && $stable(speed)
			&& $stable(active_command) && $stable(active_mode))
		else $error("result changed while stalled");

	// Only one command is in work at a time.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// A result cannot appear in the cycle right after its command arrives.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	// A new result is only written while the input side is closed.
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result produced while idle");

endmodule

bind finger_motor_task_planner fmtp_checker u_fmtp_checker (.*);

[dv/fmtp_checker.sv]
`timescale 1ns / 1ps

module fmtp_scoreboard
	import fmtp_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [2:0]                   req_type,
	input  logic [7:0]                   demand_value,
	input  logic [7:0]                   demand_max,
	input  logic [FINGERS-1:0][POS_W-1:0] finger_pos,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [7:0]                   drive_enable,
	input  logic [7:0]                   drive_direction,
	input  logic [7:0]                   speed,
	input  logic [2:0]                   active_command,
	input  logic                         active_mode,
	output int                           fail_count,
	output int                           pending,
	output int                           result_count
);

	typedef struct packed {
		logic [7:0] enable;
		logic [7:0] direction;
		logic [7:0] speed;
		cmd_t       command;
		logic       mode;
	} drive_t;

	logic [7:0]  precision_q;
	logic [7:0]  period_q;
	logic [1:0]  count_q;
	logic [63:0] clench_tgt [MODES];
	logic [63:0] release_tgt [MODES];
	logic        grip_mode;
	drive_t      held;
	drive_t      expected_drive [$];
	int          fails = 0;
	int          reported = 0;
	int          seen = 0;

	function automatic logic [7:0] scaled_speed(input logic [7:0] demand, input logic [7:0] full);
		int quotient;
		if (full == 8'd0)
			return period_q;
		quotient = (int'(demand) * int'(period_q)) / int'(full);
		return (quotient > int'(period_q)) ? period_q : 8'(quotient);
	endfunction

	function automatic void aim_fingers(input logic [63:0] tgt, input logic [7:0] demand,
			input logic [7:0] full);
		logic [7:0] t;
		logic [7:0] c;
		logic [7:0] gap;
		held.enable    = '0;
		held.direction = '0;
		for (int i = 0; i < FINGERS; i++) begin
			t = tgt[8*i +: 8];
			c = finger_pos[i];
			if (t < c) begin
				gap = c - t;
			end else begin
				gap = t - c;
				held.direction[i] = 1'b1;
			end
			if (gap >= precision_q)
				held.enable[i] = 1'b1;
		end
		held.speed = scaled_speed(demand, full);
	endfunction

	// A mode count of zero behaves as one, anything above the mode total as the total.
	function automatic int grip_modes();
		if (count_q == 2'd0)
			return 1;
		if (int'(count_q) > MODES)
			return MODES;
		return int'(count_q);
	endfunction

	function automatic drive_t predict_drive();
		case (req_type)
			CMD_GRIP: begin
				aim_fingers(clench_tgt[grip_mode], demand_value, demand_max);
				held.command = CMD_GRIP;
			end
			CMD_RELEASE: begin
				aim_fingers(release_tgt[grip_mode], demand_value, demand_max);
				held.command = CMD_RELEASE;
			end
			CMD_CLASH: begin
				held.command = CMD_CLASH;
			end
			CMD_CHANGE: begin
				grip_mode = 1'((int'(grip_mode) + 1) % grip_modes());
				// Full demand on a mode change, so the speed lands on the period.
				aim_fingers(release_tgt[grip_mode], demand_max, demand_max);
				held.command = CMD_CHANGE;
			end
			default: begin
				held.command = CMD_REST;
			end
		endcase
		held.mode = grip_mode;
		return held;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			precision_q = 8'd4;
			period_q    = 8'd255;
			count_q     = 2'd1;
			for (int m = 0; m < MODES; m++) begin
				clench_tgt[m]  = '0;
				release_tgt[m] = '0;
			end
			grip_mode = 1'b0;
			held      = '{enable: '0, direction: '0, speed: '0, command: CMD_REST, mode: 1'b0};
			expected_drive.delete();
			pending <= 0;
			fail_count <= fails;
			result_count <= seen;
		end else begin
			if (out_valid && out_ready) begin
				seen++;
				if (expected_drive.size() == 0) begin
					fails++;
					if (reported < 10)
						$display("%0t: result transfer with nothing expected: en=%h dir=%h spd=%0d",
							$time, drive_enable, drive_direction, speed);
					reported++;
				end else begin
					want = expected_drive.pop_front();
					if (drive_enable !== want.enable || drive_direction !== want.direction ||
							speed !== want.speed || active_command !== want.command ||
							active_mode !== want.mode) begin
						fails++;
						if (reported < 10) begin
							$display("%0t: mismatch, expected en=%h dir=%h spd=%0d cmd=%0d mode=%0d",
								$time, want.enable, want.direction, want.speed, want.command,
								want.mode);
							$display("%0t:           actual   en=%h dir=%h spd=%0d cmd=%0d mode=%0d",
								$time, drive_enable, drive_direction, speed, active_command,
								active_mode);
						end
						reported++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PRECISION:  precision_q    = cfg_data[7:0];
					REG_PERIOD:     period_q       = cfg_data[7:0];
					REG_MODE_COUNT: count_q        = cfg_data[1:0];
					REG_M0_CLENCH:  clench_tgt[0]  = cfg_data;
					REG_M0_RELEASE: release_tgt[0] = cfg_data;
					REG_M1_CLENCH:  clench_tgt[1]  = cfg_data;
					REG_M1_RELEASE: release_tgt[1] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_drive.push_back(predict_drive());
			fail_count <= fails;
			pending <= expected_drive.size();
			result_count <= seen;
		end
	end

endmodule

[dv/tb_finger_motor_task_planner.sv]
`timescale 1ns / 1ps

module tb_finger_motor_task_planner;
	import fmtp_pkg::*;

	localparam int RUN_LIMIT       = 600000;
	localparam int SETTLE_CYCLES   = 16;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 130;

	localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
	localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
	localparam logic [2:0] KIND_UNUSED_7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_style_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]              cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [2:0]                    req_type = CMD_REST;
	logic [7:0]                    demand_value = '0;
	logic [7:0]                    demand_max = '0;
	logic [FINGERS-1:0][POS_W-1:0] finger_pos = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [7:0]                    drive_enable;
	logic [7:0]                    drive_direction;
	logic [7:0]                    speed;
	logic [2:0]                    active_command;
	logic                          active_mode;

	int fail_count;
	int pending;
	int result_count;
	int cycle_count = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	int sent = 0;
	int settings = 0;

	logic [63:0] target_copy [4] = '{default: '0};
	logic [7:0]  precision_copy = 8'd4;

	rx_style_t rx_style = RX_OPEN;
	int        style_left = 0;
	int        rx_tick = 0;

	finger_motor_task_planner u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.demand_value    (demand_value),
		.demand_max      (demand_max),
		.current_pos_0   (finger_pos[0]),
		.current_pos_1   (finger_pos[1]),
		.current_pos_2   (finger_pos[2]),
		.current_pos_3   (finger_pos[3]),
		.current_pos_4   (finger_pos[4]),
		.current_pos_5   (finger_pos[5]),
		.current_pos_6   (finger_pos[6]),
		.current_pos_7   (finger_pos[7]),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.drive_enable    (drive_enable),
		.drive_direction (drive_direction),
		.speed           (speed),
		.active_command  (active_command),
		.active_mode     (active_mode)
	);

	fmtp_scoreboard u_check (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// The receiver switches at random between stall styles.
	always @(negedge clk) begin
		if (style_left == 0) begin
			rx_style   = rx_style_t'($urandom_range(0, 3));
			style_left = $urandom_range(50, 300);
		end
		style_left--;
		rx_tick++;
		case (rx_style)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= ($urandom_range(0, 1) == 0);
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= ((rx_tick % 7) < 4);
		endcase
	end

	task automatic send_command(input logic [2:0] kind, input logic [7:0] dval,
			input logic [7:0] dmax, input logic [FINGERS-1:0][POS_W-1:0] pos);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady && $urandom_range(0, 4) != 0)
				gap = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		req_type     = kind;
		demand_value = dval;
		demand_max   = dmax;
		finger_pos   = pos;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Registers are only touched once every result is back and the block has gone quiet.
	task automatic drain_block();
		@(negedge clk);
		in_valid   = 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx >= REG_M0_CLENCH && idx <= REG_M1_RELEASE)
			target_copy[2'(idx - REG_M0_CLENCH)] = data;
		if (idx == REG_PRECISION)
			precision_copy = data[7:0];
		repeat ($urandom_range(0, 2)) @(negedge clk);
	endtask

	// About half the fingers sit close to a programmed target so the precision threshold gets exercised.
	function automatic logic [FINGERS-1:0][POS_W-1:0] near_positions();
		logic [FINGERS-1:0][POS_W-1:0] pos;
		logic [63:0] tgt;
		int spread;
		int value;
		tgt    = target_copy[2'($urandom_range(0, 3))];
		spread = int'(precision_copy) + 2;
		for (int i = 0; i < FINGERS; i++) begin
			case ($urandom_range(0, 3))
				0: pos[i] = 8'($urandom_range(0, 255));
				1: pos[i] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
				default: begin
					value = int'(tgt[8*i +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
					if (value < 0)
						value = 0;
					if (value > 255)
						value = 255;
					pos[i] = 8'(value);
				end
			endcase
		end
		return pos;
	endfunction

	task automatic random_command();
		logic [2:0] kind;
		logic [7:0] dval;
		logic [7:0] dmax;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			kind = CMD_GRIP;
		else if (pick < 60)
			kind = CMD_RELEASE;
		else if (pick < 75)
			kind = CMD_CHANGE;
		else if (pick < 83)
			kind = CMD_REST;
		else if (pick < 91)
			kind = CMD_CLASH;
		else
			kind = 3'($urandom_range(KIND_UNUSED_5, KIND_UNUSED_7));
		dval = 8'($urandom);
		dmax = 8'($urandom);
		case ($urandom_range(0, 9))
			0: dmax = 8'd0;
			1: dval = dmax;
			2: dmax = 8'($urandom_range(1, 32));
			default: ;
		endcase
		send_command(kind, dval, dmax, near_positions());
	endtask

	initial begin
		logic [7:0]  prec;
		logic [7:0]  period;
		logic [1:0]  count;
		logic [63:0] tgt;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: zero targets, precision 4, a single grip mode.
		send_command(CMD_GRIP, 8'd128, 8'd255, '0);
		send_command(CMD_RELEASE, 8'd255, 8'd0, '1);
		send_command(CMD_CHANGE, 8'd17, 8'd90,
			{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h40, 8'hC0});
		send_command(CMD_REST, 8'd3, 8'd7, '1);
		drain_block();
		settings++;

		write_reg(REG_PRECISION, 64'd3);
		write_reg(REG_PERIOD, 64'd200);
		write_reg(REG_MODE_COUNT, 64'd2);
		write_reg(REG_M0_CLENCH, 64'hFF00_FF00_00FF_00FF);
		write_reg(REG_M0_RELEASE, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_M1_CLENCH, '1);
		write_reg(REG_M1_RELEASE, '0);
		settings++;

		// Fingers two and three steps off their clench targets, around the threshold.
		send_command(CMD_GRIP, 8'd255, 8'd1,
			{8'hFF, 8'h03, 8'hFC, 8'h02, 8'h00, 8'hFF, 8'h03, 8'hFD});
		send_command(CMD_RELEASE, 8'd0, 8'd255,
			{8'hEF, 8'hCD, 8'hAB, 8'h89, 8'h67, 8'h45, 8'h23, 8'h01});
		send_command(CMD_CLASH, 8'd50, 8'd60, '0);
		send_command(KIND_UNUSED_5, 8'd255, 8'd255, '1);
		send_command(KIND_UNUSED_6, 8'd0, 8'd0, '0);
		send_command(KIND_UNUSED_7, 8'd1, 8'd2, '1);
		send_command(CMD_CHANGE, 8'd9, 8'd200, '0);
		send_command(CMD_GRIP, 8'd100, 8'd100, '0);
		send_command(CMD_RELEASE, 8'd1, 8'd255, '1);
		send_command(CMD_CHANGE, 8'd255, 8'd13, '1);
		send_command(CMD_CHANGE, 8'd40, 8'd0, '0);
		send_command(CMD_GRIP, 8'd128, 8'd0,
			{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
		send_command(CMD_REST, 8'd0, 8'd0, '0);
		drain_block();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			prec   = 8'($urandom);
			period = 8'($urandom);
			count  = 2'($urandom_range(0, 3));
			case (phase)
				0: begin
					prec   = 8'd0;
					period = 8'd255;
					count  = 2'd2;
				end
				1: begin
					prec   = 8'd255;
					period = 8'd0;
					count  = 2'd3;
				end
				2: count = 2'd0;
				3: begin
					prec   = 8'd1;
					period = 8'd1;
					count  = 2'd1;
				end
				default: ;
			endcase
			// Upper data bits are random; the narrow registers must ignore them.
			write_reg(REG_PRECISION, {32'($urandom), 24'($urandom), prec});
			write_reg(REG_PERIOD, {32'($urandom), 24'($urandom), period});
			write_reg(REG_MODE_COUNT, {32'($urandom), 30'($urandom), count});
			for (int r = 0; r < 4; r++) begin
				case ($urandom_range(0, 5))
					0: tgt = '0;
					1: tgt = '1;
					default: tgt = {32'($urandom), 32'($urandom)};
				endcase
				write_reg(CFG_IDX_W'(REG_M0_CLENCH + r), tgt);
			end
			if (phase == 5)
				write_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
			settings++;

			steady = (phase == 3);
			repeat (ITEMS_PER_PHASE) random_command();
			drain_block();
		end
		steady = 1'b0;

		repeat (20) @(posedge clk);
		$display("Sent %0d commands under %0d register settings; %0d results checked.",
			sent, settings, result_count);
		$display("Settings spanned precision and period extremes and mode counts zero to three.");
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[finger_motor_task_planner.f]
design/fmtp_pkg.sv
design/fmtp_ctrl.sv
design/fmtp_datapath.sv
design/finger_motor_task_planner.sv
design/fmtp_checker.sv
dv/fmtp_checker.sv
dv/tb_finger_motor_task_planner.sv
